// ===== src/spq_pkg.sv =====
package spq_pkg;

    // Default sizes of the queue.
    localparam int DEPTH_DEF        = 16;
    localparam int KEY_BITS_DEF     = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Command codes on the action field.
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // Status codes returned with every result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_CLEAR
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     sorted;
    } t_cell_cmd;

endpackage

// ===== src/sorted_insert_priority_queue.sv =====
// Channel     | Direction | Handshake                  | Payload
// ------------+-----------+----------------------------+---------------------------------
// command     | in        | start, busy                | i_action, i_item_key,
//             |           |                            | i_item_payload
// result      | out       | o_strobe (one cycle)       | o_out_valid, o_out_key,
//             |           |                            | o_out_payload, o_status,
//             |           |                            | o_entry_total, o_is_empty
// config      | in        | i_cfg_valid, o_cfg_ready   | i_cfg_data (order_mode)
//
// For every command, the whole chain of cells updates at the edge that accepts it,
// and its result appears on the result ports in the following cycle.
// Busy is never raised, so a command may be transferred in every cycle.
// The insert position is found by a flag that ripples through the chain of cells
// within the accepting cycle, so the chain length sets the critical path.
// Reset (synchronous, active low) empties the queue and selects sorted order.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_insert_priority_queue #(
    parameter int DEPTH        = spq_pkg::DEPTH_DEF,
    parameter int KEY_BITS     = spq_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_action,
    input  logic [KEY_BITS-1:0]           i_item_key,
    input  logic [PAYLOAD_BITS-1:0]       i_item_payload,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data,
    output logic                          o_strobe,
    output logic                          o_out_valid,
    output logic [KEY_BITS-1:0]           o_out_key,
    output logic [PAYLOAD_BITS-1:0]       o_out_payload,
    output logic [1:0]                    o_status,
    output logic [$clog2(DEPTH+1)-1:0]    o_entry_total,
    output logic                          o_is_empty
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                    r_order_mode;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;

    logic                    w_accept;
    logic                    w_full;
    logic                    w_empty;
    t_cell_cmd               w_cmd;

    // Result fields computed in the accepting cycle, registered onto the ports.
    logic                    n_out_valid;
    logic [KEY_BITS-1:0]     n_out_key;
    logic [PAYLOAD_BITS-1:0] n_out_payload;
    logic [1:0]              n_status;

    // Per-cell taps of the chain.
    logic [KEY_BITS-1:0]     w_key     [DEPTH];
    logic [PAYLOAD_BITS-1:0] w_payload [DEPTH];
    logic                    w_occ     [DEPTH];
    logic                    w_shift   [DEPTH];

    // The queue never holds a command off.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start & ~busy;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    // Decode the command into one operation for the whole chain. A rejected insert
    // or remove, an unused action code and an idle cycle all leave the cells alone.
    always_comb begin
        w_cmd.sorted  = r_order_mode;
        w_cmd.op      = OP_HOLD;
        n_count       = r_count;
        n_out_valid   = 1'b0;
        n_out_key     = '0;
        n_out_payload = '0;
        n_status      = ST_OK;
        if (w_accept) begin
            unique case (i_action)
                ACT_INSERT: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_cmd.op = OP_INSERT;
                        n_count  = r_count + CNT_W'(1);
                    end
                end
                ACT_REMOVE: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_cmd.op      = OP_REMOVE;
                        n_count       = r_count - CNT_W'(1);
                        n_out_valid   = 1'b1;
                        n_out_key     = w_key[0];
                        n_out_payload = w_payload[0];
                    end
                end
                ACT_CLEAR: begin
                    w_cmd.op = OP_CLEAR;
                    n_count  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // The chain: cell 0 holds the head. Each cell sees its neighbour on either side;
    // the cells at both ends see an empty neighbour.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [KEY_BITS-1:0]     w_prev_key;
        logic [PAYLOAD_BITS-1:0] w_prev_payload;
        logic                    w_prev_occ;
        logic                    w_prev_shift;
        logic [KEY_BITS-1:0]     w_next_key;
        logic [PAYLOAD_BITS-1:0] w_next_payload;
        logic                    w_next_occ;

        if (g == 0) begin : g_first
            assign w_prev_key     = '0;
            assign w_prev_payload = '0;
            assign w_prev_occ     = 1'b0;
            assign w_prev_shift   = 1'b0;
        end else begin : g_inner_prev
            assign w_prev_key     = w_key[g-1];
            assign w_prev_payload = w_payload[g-1];
            assign w_prev_occ     = w_occ[g-1];
            assign w_prev_shift   = w_shift[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next_key     = '0;
            assign w_next_payload = '0;
            assign w_next_occ     = 1'b0;
        end else begin : g_inner_next
            assign w_next_key     = w_key[g+1];
            assign w_next_payload = w_payload[g+1];
            assign w_next_occ     = w_occ[g+1];
        end

        spq_cell #(
            .KEY_BITS     (KEY_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_cmd          (w_cmd),
            .i_new_key      (i_item_key),
            .i_new_payload  (i_item_payload),
            .i_prev_key     (w_prev_key),
            .i_prev_payload (w_prev_payload),
            .i_prev_occ     (w_prev_occ),
            .i_prev_shift   (w_prev_shift),
            .i_next_key     (w_next_key),
            .i_next_payload (w_next_payload),
            .i_next_occ     (w_next_occ),
            .o_key          (w_key[g]),
            .o_payload      (w_payload[g]),
            .o_occ          (w_occ[g]),
            .o_shift        (w_shift[g])
        );
    end

    // Control state: mode register, entry count and the result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_mode <= 1'b1;
            r_count      <= '0;
            o_strobe     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_order_mode <= i_cfg_data;
            end
            r_count  <= n_count;
            o_strobe <= w_accept;
        end
    end

    // Result registers; they only mean something while the strobe is high.
    always_ff @(posedge i_clk) begin
        o_out_valid   <= n_out_valid;
        o_out_key     <= n_out_key;
        o_out_payload <= n_out_payload;
        o_status      <= n_status;
        o_entry_total <= n_count;
        o_is_empty    <= (n_count == '0);
    end

endmodule

// ===== src/spq_cell.sv =====
module spq_cell #(
    parameter int KEY_BITS     = spq_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  spq_pkg::t_cell_cmd      i_cmd,
    input  logic [KEY_BITS-1:0]     i_new_key,
    input  logic [PAYLOAD_BITS-1:0] i_new_payload,
    input  logic [KEY_BITS-1:0]     i_prev_key,
    input  logic [PAYLOAD_BITS-1:0] i_prev_payload,
    input  logic                    i_prev_occ,
    input  logic                    i_prev_shift,
    input  logic [KEY_BITS-1:0]     i_next_key,
    input  logic [PAYLOAD_BITS-1:0] i_next_payload,
    input  logic                    i_next_occ,
    output logic [KEY_BITS-1:0]     o_key,
    output logic [PAYLOAD_BITS-1:0] o_payload,
    output logic                    o_occ,
    output logic                    o_shift
);
    import spq_pkg::*;

    logic [KEY_BITS-1:0]     r_key;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic                    r_occ;
    logic [KEY_BITS-1:0]     n_key;
    logic [PAYLOAD_BITS-1:0] n_payload;
    logic                    n_occ;
    logic                    w_gt;

    // This cell and everything behind it moves back on an insert once an earlier
    // cell has moved, once this cell is free, or, in sorted order, once its key is strictly greater.
    assign w_gt    = i_cmd.sorted & (r_key > i_new_key);
    assign o_shift = i_prev_shift | ~r_occ | w_gt;

    always_comb begin
        n_key     = r_key;
        n_payload = r_payload;
        n_occ     = r_occ;
        unique case (i_cmd.op)
            OP_INSERT: begin
                if (i_prev_shift) begin
                    n_key     = i_prev_key;
                    n_payload = i_prev_payload;
                    n_occ     = i_prev_occ;
                end else if (o_shift) begin
                    n_key     = i_new_key;
                    n_payload = i_new_payload;
                    n_occ     = 1'b1;
                end
            end
            OP_REMOVE: begin
                n_key     = i_next_key;
                n_payload = i_next_payload;
                n_occ     = i_next_occ;
            end
            OP_CLEAR: begin
                n_occ = 1'b0;
            end
            OP_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_payload <= n_payload;
    end

    assign o_key     = r_key;
    assign o_payload = r_payload;
    assign o_occ     = r_occ;

endmodule

// ===== src/spq_checker.sv =====
module spq_checker #(
    parameter int DEPTH        = spq_pkg::DEPTH_DEF,
    parameter int KEY_BITS     = spq_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_strobe,
    input logic                       o_out_valid,
    input logic [KEY_BITS-1:0]        o_out_key,
    input logic [PAYLOAD_BITS-1:0]    o_out_payload,
    input logic [1:0]                 o_status,
    input logic [$clog2(DEPTH+1)-1:0] o_entry_total,
    input logic                       o_is_empty
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Each transferred command yields exactly one result in the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_strobe)
        else $error("command transferred without a result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_strobe)
        else $error("result without a transferred command");

    // A rejected insert only happens on a full queue and returns no entry.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_FULL) |->
            (!o_out_valid && o_entry_total == CNT_W'(DEPTH)))
        else $error("insert rejected although the queue was not full");

    // A rejected remove only happens on an empty queue.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_EMPTY) |->
            (!o_out_valid && o_is_empty && o_entry_total == '0))
        else $error("remove rejected although the queue held entries");

    // The empty flag agrees with the entry total.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_is_empty == (o_entry_total == '0)))
        else $error("empty flag disagrees with entry total");

endmodule

bind sorted_insert_priority_queue spq_checker #(
    .DEPTH        (DEPTH),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
) u_spq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_out_valid   (o_out_valid),
    .o_out_key     (o_out_key),
    .o_out_payload (o_out_payload),
    .o_status      (o_status),
    .o_entry_total (o_entry_total),
    .o_is_empty    (o_is_empty)
);

// ===== tb/tb_sorted_insert_priority_queue.sv =====
module tb_sorted_insert_priority_queue;

    // Self-checking bench for the sorted insert priority queue.
    //
    // A driver block feeds commands from a backlog that the stimulus block fills before
    // reset is released. At every edge where a command transfer takes place, the driver
    // runs it through a local copy of the queue and files the outcome that the block
    // must report. A monitor block compares every strobed result, field by field, with
    // the oldest filed outcome. Writes of the order register are taken from the same
    // backlog and are only made once every outcome that is due has been checked.

    import spq_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int KEY_BITS     = KEY_BITS_DEF;
    localparam int PAYLOAD_BITS = PAYLOAD_BITS_DEF;
    localparam int CNT_BITS     = $clog2(DEPTH + 1);
    localparam int CLK_PERIOD   = 4;
    localparam int LIMIT_CYCLES = 200_000;

    // The fourth action code is not defined by the block and must be ignored by it.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Values of the order register.
    localparam logic ORDER_FIFO   = 1'b0;
    localparam logic ORDER_SORTED = 1'b1;

    typedef logic [KEY_BITS-1:0]     t_key;
    typedef logic [PAYLOAD_BITS-1:0] t_pay;
    typedef logic [CNT_BITS-1:0]     t_cnt;

    // One result as the block reports it.
    typedef struct packed {
        logic       valid;
        t_key       key;
        t_pay       payload;
        logic [1:0] status;
        t_cnt       total;
        logic       empty;
    } t_step_outcome;

    // Work held in the backlog: a command, a write of the order register, or a wait
    // until every filed outcome has been checked.
    typedef enum logic [1:0] {
        JOB_COMMAND,
        JOB_ORDER_WRITE,
        JOB_DRAIN_WAIT
    } t_job_kind;

    typedef struct {
        t_job_kind  kind;
        logic [1:0] action;
        t_key       key;
        t_pay       payload;
        logic       order;
        int         gap;
    } t_job;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [1:0] i_action;
    t_key i_item_key;
    t_pay i_item_payload;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic i_cfg_data;
    logic o_strobe;
    logic o_out_valid;
    t_key o_out_key;
    t_pay o_out_payload;
    logic [1:0] o_status;
    t_cnt o_entry_total;
    logic o_is_empty;

    t_job          cmd_backlog[$];
    t_step_outcome expected_outcomes[$];

    // Local copy of the queue contents and of the order register.
    t_key q_key[DEPTH];
    t_pay q_pay[DEPTH];
    int   q_len;
    logic sorted_mode;

    int   mismatches;
    int   idle_run;
    logic stim_idle;

    sorted_insert_priority_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_item_key     (i_item_key),
        .i_item_payload (i_item_payload),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_out_valid    (o_out_valid),
        .o_out_key      (o_out_key),
        .o_out_payload  (o_out_payload),
        .o_status       (o_status),
        .o_entry_total  (o_entry_total),
        .o_is_empty     (o_is_empty)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Applies one command to the local queue and returns what the block must report.
    // In sorted order a new entry goes in front of the first entry with a strictly
    // greater key, so that entries with equal keys leave in the order they came.
    function automatic t_step_outcome apply_command(input logic [1:0] act, input t_key key,
                                                    input t_pay pay);
        t_step_outcome r;
        int            slot;
        int            i;
        r        = '0;
        r.status = ST_OK;
        case (act)
            ACT_INSERT: begin
                if (q_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    slot = q_len;
                    if (sorted_mode) begin
                        for (i = q_len - 1; i >= 0; i--) begin
                            if (q_key[i] > key) slot = i;
                        end
                    end
                    for (i = q_len; i > slot; i--) begin
                        q_key[i] = q_key[i-1];
                        q_pay[i] = q_pay[i-1];
                    end
                    q_key[slot] = key;
                    q_pay[slot] = pay;
                    q_len++;
                end
            end
            ACT_REMOVE: begin
                if (q_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.valid   = 1'b1;
                    r.key     = q_key[0];
                    r.payload = q_pay[0];
                    for (i = 1; i < q_len; i++) begin
                        q_key[i-1] = q_key[i];
                        q_pay[i-1] = q_pay[i];
                    end
                    q_len--;
                end
            end
            ACT_CLEAR: begin
                q_len = 0;
            end
            default: begin
            end
        endcase
        r.total = t_cnt'(q_len);
        r.empty = (q_len == 0);
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic add_command(input logic [1:0] act, input t_key key, input t_pay pay,
                               input int gap);
        t_job j;
        j.kind    = JOB_COMMAND;
        j.action  = act;
        j.key     = key;
        j.payload = pay;
        j.order   = 1'b0;
        j.gap     = gap;
        cmd_backlog.push_back(j);
    endtask

    task automatic add_control(input t_job_kind kind, input logic order);
        t_job j;
        j.kind    = kind;
        j.action  = ACT_INSERT;
        j.key     = '0;
        j.payload = '0;
        j.order   = order;
        j.gap     = 0;
        cmd_backlog.push_back(j);
    endtask

    // Draws a key in one of several styles. A narrow range makes equal keys common,
    // which is what shows whether ties keep their arrival order.
    function automatic t_key draw_key(input int style);
        t_key k;
        case (style)
            0: k = t_key'($urandom_range(0, 3));
            1: k = t_key'($urandom);
            2: begin
                case ($urandom_range(0, 3))
                    0: k = '0;
                    1: k = '1;
                    2: k = {1'b1, {(KEY_BITS-1){1'b0}}};
                    default: k = {1'b0, {(KEY_BITS-1){1'b1}}};
                endcase
            end
            default: k = t_key'({KEY_BITS{1'b1}} - $urandom_range(0, 15));
        endcase
        return k;
    endfunction

    // A stretch of random commands with one leaning: mostly inserts to reach the full
    // queue, mostly removals to reach the empty one, or an even mix.
    task automatic add_random_stretch(input int n, input bit calm);
        int         lean;
        int         style;
        int         ins_pct;
        int         rem_pct;
        int         roll;
        int         gap;
        bit         bursty;
        logic [1:0] act;
        lean   = $urandom_range(0, 2);
        style  = $urandom_range(0, 3);
        bursty = !calm && ($urandom_range(0, 2) != 0);
        case (lean)
            0:       begin ins_pct = 80; rem_pct = 15; end
            1:       begin ins_pct = 15; rem_pct = 80; end
            default: begin ins_pct = 48; rem_pct = 48; end
        endcase
        repeat (n) begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)                act = ACT_INSERT;
            else if (roll < ins_pct + rem_pct) act = ACT_REMOVE;
            else if (roll < 99)                act = ACT_CLEAR;
            else                               act = ACT_UNUSED;
            gap = 0;
            if (bursty && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 5);
            add_command(act, draw_key(style), t_pay'($urandom), gap);
        end
    endtask

    // Driver. Command and register channels are sampled at the edge as they were in the
    // cycle it ends; start, i_cfg_valid and stim_idle get one assignment each per edge.
    always @(posedge i_clk) begin
        logic nstart;
        logic ncfg;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
            stim_idle   <= 1'b0;
            q_len       = 0;
            sorted_mode = ORDER_SORTED;
            idle_run    = 0;
        end else begin
            // A command transfer: file the outcome that it must produce.
            if (start && !busy) begin
                expected_outcomes.push_back(apply_command(i_action, i_item_key,
                                                          i_item_payload));
            end
            // A register transfer changes the order for later inserts only.
            if (i_cfg_valid && o_cfg_ready) sorted_mode = i_cfg_data;

            nstart = start && busy;
            ncfg   = i_cfg_valid && !o_cfg_ready;

            if (!nstart && !ncfg && cmd_backlog.size() != 0) begin
                case (cmd_backlog[0].kind)
                    JOB_COMMAND: begin
                        if (idle_run >= cmd_backlog[0].gap) begin
                            i_action       <= cmd_backlog[0].action;
                            i_item_key     <= cmd_backlog[0].key;
                            i_item_payload <= cmd_backlog[0].payload;
                            nstart   = 1'b1;
                            idle_run = 0;
                            void'(cmd_backlog.pop_front());
                        end else begin
                            idle_run++;
                        end
                    end
                    JOB_ORDER_WRITE: begin
                        // The register is only written once the queue has gone quiet.
                        if (expected_outcomes.size() == 0) begin
                            i_cfg_data <= cmd_backlog[0].order;
                            ncfg = 1'b1;
                            void'(cmd_backlog.pop_front());
                        end
                    end
                    default: begin
                        if (expected_outcomes.size() == 0) void'(cmd_backlog.pop_front());
                    end
                endcase
            end

            start       <= nstart;
            i_cfg_valid <= ncfg;
            stim_idle   <= !nstart && !ncfg && (cmd_backlog.size() == 0);
        end
    end

    // Monitor. The receiver cannot hold results off, so every strobed cycle is a
    // result transfer and is checked against the oldest filed outcome.
    always @(posedge i_clk) begin
        t_step_outcome want;
        if (i_rst_n) begin
            if ($isunknown(o_strobe)) begin
                flag_mismatch("result strobe is unknown");
            end else if (o_strobe) begin
                if (expected_outcomes.size() == 0) begin
                    flag_mismatch("result strobed with no command outstanding");
                end else begin
                    want = expected_outcomes.pop_front();
                    if (o_out_valid !== want.valid)
                        flag_mismatch($sformatf("out_valid %b, want %b",
                                                o_out_valid, want.valid));
                    if (o_out_key !== want.key)
                        flag_mismatch($sformatf("out_key %h, want %h", o_out_key, want.key));
                    if (o_out_payload !== want.payload)
                        flag_mismatch($sformatf("out_payload %h, want %h",
                                                o_out_payload, want.payload));
                    if (o_status !== want.status)
                        flag_mismatch($sformatf("status %0d, want %0d",
                                                o_status, want.status));
                    if (o_entry_total !== want.total)
                        flag_mismatch($sformatf("entry_total %0d, want %0d",
                                                o_entry_total, want.total));
                    if (o_is_empty !== want.empty)
                        flag_mismatch($sformatf("is_empty %b, want %b",
                                                o_is_empty, want.empty));
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int phase;
        int made;
        int n;
        int i;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_action       = ACT_INSERT;
        i_item_key     = '0;
        i_item_payload = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = ORDER_SORTED;
        mismatches     = 0;

        // Directed part, in sorted order: a removal from the empty queue, the key
        // extremes, a tie on equal keys, the unused action code, removals, a clear,
        // and then a fill to the full depth followed by an insert that is turned away.
        add_control(JOB_ORDER_WRITE, ORDER_SORTED);
        add_command(ACT_REMOVE, '0, '0, 0);
        add_command(ACT_INSERT, '1, '1, 0);
        add_command(ACT_INSERT, '0, '0, 1);
        add_command(ACT_INSERT, t_key'(5), t_pay'(32'hA5A5_A5A5), 0);
        add_command(ACT_INSERT, t_key'(5), t_pay'(32'h5A5A_5A5A), 0);
        add_command(ACT_UNUSED, '1, t_pay'($urandom), 2);
        add_command(ACT_REMOVE, '1, '1, 0);
        add_command(ACT_REMOVE, '0, '0, 0);
        add_command(ACT_CLEAR, '0, '0, 0);
        for (i = 0; i < DEPTH; i++)
            add_command(ACT_INSERT, t_key'((DEPTH - 1 - i) / 2), t_pay'(i),
                        (i % 3 == 0) ? 1 : 0);
        add_command(ACT_INSERT, '0, '1, 0);

        // Random phases, alternating the order register between its two values. The
        // queue keeps its contents across a change of order.
        for (phase = 0; phase < 6; phase++) begin
            add_control(JOB_ORDER_WRITE, (phase % 2 == 0) ? ORDER_FIFO : ORDER_SORTED);
            made = 0;
            while (made < 215) begin
                n = $urandom_range(6, 30);
                add_random_stretch(n, 1'b0);
                made += n;
                if ($urandom_range(0, 7) == 0) add_control(JOB_DRAIN_WAIT, 1'b0);
            end
        end

        // The sender holds off until every result is in, then a closing part with
        // no idle cycles at all.
        add_control(JOB_DRAIN_WAIT, 1'b0);
        made = 0;
        while (made < 120) begin
            n = $urandom_range(6, 30);
            add_random_stretch(n, 1'b1);
            made += n;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (!stim_idle || expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (expected_outcomes.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_outcomes.size()));

        if (mismatches == 0) begin
            $display("[sorted_insert_priority_queue] OK");
        end else begin
            $display("[sorted_insert_priority_queue] ERROR");
        end
        $finish;
    end

    // Watchdog for a run that hangs.
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("[sorted_insert_priority_queue] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_insert_priority_queue.sv
src/spq_checker.sv
tb/tb_sorted_insert_priority_queue.sv
